>>> hw/rtl/shc_pkg.sv
// Package with the types, codes and helpers shared by the stepper homing controller.
package shc_pkg;

    // Command codes carried in the opcode field
    typedef enum logic [3:0] {
        OP_TICK         = 4'd0,
        OP_STEP1_TOWARD = 4'd1,
        OP_STEP1_AWAY   = 4'd2,
        OP_STEP2_TOWARD = 4'd3,
        OP_STEP2_AWAY   = 4'd4,
        OP_HOME         = 4'd5,
        OP_READ_SW1     = 4'd6,
        OP_READ_SW2     = 4'd7
    } shc_op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_MASK = 2'd1,
        ST_UNKNOWN  = 2'd2,
        ST_REJECTED = 2'd3
    } shc_status_t;

    // Sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SETTLE  = 3'd1,
        PH_LOW     = 3'd2,
        PH_HIGH    = 3'd3,
        PH_HSETTLE = 3'd4,
        PH_HLOW    = 3'd5,
        PH_HHIGH   = 3'd6
    } shc_phase_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_HOME_DIR1  = 2'd0,
        CFG_HOME_DIR2  = 2'd1,
        CFG_STEP_DELAY = 2'd2
    } shc_cfg_idx_t;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned DELAY_W    = 16;
    localparam int unsigned STEPS_W    = 32;

    // One input item
    typedef struct packed {
        logic [3:0]         opcode;
        logic [STEPS_W-1:0] argument;
        logic               limit_switch1;
        logic               limit_switch2;
    } shc_in_t;

    // One result item
    typedef struct packed {
        logic       step_level1;
        logic       dir_level1;
        logic       step_level2;
        logic       dir_level2;
        logic       busy_res;
        logic [1:0] status;
        logic       switch_value;
    } shc_out_t;

    // Configuration seen by the sequencer
    typedef struct packed {
        logic               home_dir1;
        logic               home_dir2;
        logic [DELAY_W-1:0] step_delay;
    } shc_cfg_t;

    // Delay reload value: a zero delay counts as one tick.
    function automatic logic [DELAY_W-1:0] shc_load_delay(input logic [DELAY_W-1:0] d);
        shc_load_delay = (d == '0) ? DELAY_W'(1) : d;
    endfunction

endpackage

>>> hw/rtl/shc_cfg_regs.sv
// Configuration registers of the stepper homing controller.
module shc_cfg_regs
    import shc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output shc_cfg_t              cfg
);

    logic               home_dir1_reg;
    logic               home_dir2_reg;
    logic [DELAY_W-1:0] step_delay_reg;

    // Register writes decoded by index; unused indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_dir1_reg  <= 1'b0;
            home_dir2_reg  <= 1'b0;
            step_delay_reg <= DELAY_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HOME_DIR1:  home_dir1_reg  <= cfg_data[0];
                CFG_HOME_DIR2:  home_dir2_reg  <= cfg_data[0];
                CFG_STEP_DELAY: step_delay_reg <= cfg_data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.home_dir1  = home_dir1_reg;
    assign cfg.home_dir2  = home_dir2_reg;
    assign cfg.step_delay = step_delay_reg;

endmodule

>>> hw/rtl/shc_core.sv
// Step and homing sequencer: state registers and the per-item update.
module shc_core
    import shc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  shc_in_t  item,
    input  shc_cfg_t cfg,
    output shc_out_t result
);

    shc_phase_t         phase_reg, phase_next;
    logic [DELAY_W-1:0] delay_count_reg, delay_count_next;
    logic [STEPS_W-1:0] steps_left_reg, steps_left_next;
    logic               active_axis_reg, active_axis_next;
    logic [1:0]         homing_axes_reg, homing_axes_next;
    logic [1:0]         step_levels_reg, step_levels_next;
    logic [1:0]         dir_levels_reg, dir_levels_next;

    logic               busy;
    logic               expired;
    logic [STEPS_W-1:0] steps_dec;
    logic [1:0]         axis_mask;
    logic [1:0]         switches;
    logic [DELAY_W-1:0] reload;

    assign busy      = (phase_reg != PH_IDLE);
    assign expired   = (delay_count_reg <= DELAY_W'(1));
    assign steps_dec = steps_left_reg - STEPS_W'(1);
    assign axis_mask = active_axis_reg ? 2'b10 : 2'b01;
    assign switches  = {item.limit_switch2, item.limit_switch1};
    assign reload    = shc_load_delay(cfg.step_delay);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (item.opcode) inside
                OP_TICK:
                begin
                    if (busy && expired)
                    begin
                        unique case (phase_reg)
                            PH_SETTLE:  phase_next = (steps_left_reg == '0) ? PH_IDLE : PH_LOW;
                            PH_LOW:     phase_next = PH_HIGH;
                            PH_HIGH:    phase_next = (steps_dec == '0) ? PH_IDLE : PH_LOW;
                            PH_HSETTLE,
                            PH_HHIGH:   phase_next = (switches == 2'b00) ? PH_IDLE : PH_HLOW;
                            PH_HLOW:    phase_next = PH_HHIGH;
                            default:    phase_next = PH_IDLE;
                        endcase
                    end
                end
                [OP_STEP1_TOWARD:OP_STEP2_AWAY]:
                begin
                    if (!busy)
                        phase_next = PH_SETTLE;
                end
                OP_HOME:
                begin
                    if (!busy && (item.argument[STEPS_W-1:2] == '0))
                        phase_next = PH_HSETTLE;
                end
                default: ;
            endcase
        end
    end

    // Counters, pin levels and the result of the item
    always_comb
    begin
        logic level;
        logic axis;

        delay_count_next = delay_count_reg;
        steps_left_next  = steps_left_reg;
        active_axis_next = active_axis_reg;
        homing_axes_next = homing_axes_reg;
        step_levels_next = step_levels_reg;
        dir_levels_next  = dir_levels_reg;
        result.status       = ST_OK;
        result.switch_value = 1'b0;
        level = 1'b0;
        axis  = 1'b0;

        if (accept)
        begin
            case (item.opcode) inside
                OP_TICK:
                begin
                    if (busy)
                    begin
                        if (!expired)
                        begin
                            delay_count_next = delay_count_reg - DELAY_W'(1);
                        end
                        else
                        begin
                            delay_count_next = '0;
                            case (phase_reg)
                                PH_SETTLE:
                                begin
                                    if (steps_left_reg != '0)
                                    begin
                                        step_levels_next = step_levels_reg & ~axis_mask;
                                        delay_count_next = reload;
                                    end
                                end
                                PH_LOW:
                                begin
                                    step_levels_next = step_levels_reg | axis_mask;
                                    delay_count_next = reload;
                                end
                                PH_HIGH:
                                begin
                                    steps_left_next = steps_dec;
                                    if (steps_dec != '0)
                                    begin
                                        step_levels_next = step_levels_reg & ~axis_mask;
                                        delay_count_next = reload;
                                    end
                                end
                                PH_HSETTLE, PH_HHIGH:
                                begin
                                    homing_axes_next = switches;
                                    if (switches != 2'b00)
                                    begin
                                        step_levels_next = step_levels_reg & ~switches;
                                        delay_count_next = reload;
                                    end
                                end
                                PH_HLOW:
                                begin
                                    step_levels_next = step_levels_reg | homing_axes_reg;
                                    delay_count_next = reload;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                [OP_STEP1_TOWARD:OP_STEP2_AWAY]:
                begin
                    if (busy)
                    begin
                        result.status = ST_REJECTED;
                    end
                    else
                    begin
                        axis  = (item.opcode >= OP_STEP2_TOWARD);
                        level = axis ? cfg.home_dir2 : cfg.home_dir1;
                        if ((item.opcode == OP_STEP1_AWAY) || (item.opcode == OP_STEP2_AWAY))
                            level = ~level;
                        dir_levels_next[axis] = level;
                        active_axis_next = axis;
                        steps_left_next  = item.argument;
                        delay_count_next = reload;
                    end
                end
                OP_HOME:
                begin
                    if (busy)
                        result.status = ST_REJECTED;
                    else if (item.argument[STEPS_W-1:2] != '0)
                        result.status = ST_BAD_MASK;
                    else
                    begin
                        dir_levels_next  = {cfg.home_dir2, cfg.home_dir1};
                        homing_axes_next = 2'b00;
                        delay_count_next = reload;
                    end
                end
                OP_READ_SW1:
                begin
                    if (busy)
                        result.status = ST_REJECTED;
                    else
                        result.switch_value = item.limit_switch1;
                end
                OP_READ_SW2:
                begin
                    if (busy)
                        result.status = ST_REJECTED;
                    else
                        result.switch_value = item.limit_switch2;
                end
                default:
                begin
                    result.status = ST_UNKNOWN;
                end
            endcase
        end

        result.step_level1 = step_levels_next[0];
        result.dir_level1  = dir_levels_next[0];
        result.step_level2 = step_levels_next[1];
        result.dir_level2  = dir_levels_next[1];
        result.busy_res    = (phase_next != PH_IDLE);
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            delay_count_reg <= '0;
            steps_left_reg  <= '0;
            active_axis_reg <= 1'b0;
            homing_axes_reg <= 2'b00;
            step_levels_reg <= 2'b00;
            dir_levels_reg  <= 2'b00;
        end
        else
        begin
            phase_reg       <= phase_next;
            delay_count_reg <= delay_count_next;
            steps_left_reg  <= steps_left_next;
            active_axis_reg <= active_axis_next;
            homing_axes_reg <= homing_axes_next;
            step_levels_reg <= step_levels_next;
            dir_levels_reg  <= dir_levels_next;
        end
    end

endmodule

>>> hw/rtl/shc_out_reg.sv
// Result register that holds one finished result until its transfer.
module shc_out_reg
    import shc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  shc_out_t load_data,
    output logic     space,
    output logic     out_valid,
    input  logic     out_ready,
    output shc_out_t out_data
);

    logic     valid_reg;
    shc_out_t data_reg;

    // A new result may enter when the register is empty or is being drained.
    assign space = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hw/rtl/two_axis_stepper_homing_controller.sv
// A result is registered at its input transfer and offered in the next cycle.
// Throughput: one item per cycle; the state update is done at the input transfer
// and the result register drains while the next item is taken.
// Input ready is low only while a held result waits and the output is stalled.
// Reset (rst_n, asynchronous, active low) clears the sequencer to idle with all pins low,
// home directions to 0 and the step delay to 1.
module two_axis_stepper_homing_controller
    import shc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  shc_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output shc_out_t              out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    shc_cfg_t cfg;
    shc_out_t result;
    logic     accept;

    assign accept = in_valid && in_ready;

    shc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    shc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_data),
        .cfg    (cfg),
        .result (result)
    );

    shc_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (result),
        .space     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> dv/shc_motion_checker.sv
// Checker for the stepper homing controller: predicts each result and compares it.
`timescale 1ns / 100ps

module shc_motion_checker
    import shc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  shc_in_t               in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  shc_out_t              out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  run_done,
    output int                    fail_count,
    output int                    pending,
    output logic                  seq_busy,
    output int                    results_seen
);

    // Expected pin and status results, oldest first.
    shc_out_t expected_pins_q[$];

    // Shadow of the configuration registers.
    logic               home_dir1_r;
    logic               home_dir2_r;
    logic [DELAY_W-1:0] delay_r;

    // Shadow of the sequencer state.
    shc_phase_t         phase_r;
    logic [DELAY_W-1:0] count_r;
    logic [STEPS_W-1:0] steps_r;
    logic               axis_r;
    logic [1:0]         homing_r;
    logic [1:0]         step_r;
    logic [1:0]         dir_r;

    int mismatches;
    int checked;
    bit leftover_flagged;

    // A programmed delay of zero still waits one tick.
    function automatic logic [DELAY_W-1:0] reload_value();
        return (delay_r == '0) ? DELAY_W'(1) : delay_r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] checker: result %0d: %s", $time, checked, what);
    endtask

    task automatic check_field(input string name, input logic [1:0] got, input logic [1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task automatic drive_step_pins(input logic [1:0] mask, input logic level);
        step_r = level ? (step_r | mask) : (step_r & ~mask);
    endtask

    // One millisecond tick through the step and homing phases.
    task automatic advance_tick(input logic sw1, input logic sw2);
        logic [1:0] axis_mask;
        axis_mask = axis_r ? 2'b10 : 2'b01;
        if (phase_r == PH_IDLE)
            return;
        if (count_r > DELAY_W'(1))
        begin
            count_r = count_r - DELAY_W'(1);
            return;
        end
        count_r = '0;
        case (phase_r)
            PH_SETTLE, PH_HIGH:
            begin
                if (phase_r == PH_HIGH)
                    steps_r = steps_r - STEPS_W'(1);
                if (steps_r == '0)
                    phase_r = PH_IDLE;
                else
                begin
                    drive_step_pins(axis_mask, 1'b0);
                    phase_r = PH_LOW;
                    count_r = reload_value();
                end
            end
            PH_LOW:
            begin
                drive_step_pins(axis_mask, 1'b1);
                phase_r = PH_HIGH;
                count_r = reload_value();
            end
            PH_HSETTLE, PH_HHIGH:
            begin
                // Switches are sampled again after every full homing pulse.
                homing_r = {sw2, sw1};
                if (homing_r == 2'b00)
                    phase_r = PH_IDLE;
                else
                begin
                    drive_step_pins(homing_r, 1'b0);
                    phase_r = PH_HLOW;
                    count_r = reload_value();
                end
            end
            PH_HLOW:
            begin
                drive_step_pins(homing_r, 1'b1);
                phase_r = PH_HHIGH;
                count_r = reload_value();
            end
            default:
                phase_r = PH_IDLE;
        endcase
    endtask

    // Works out the result of one input item and updates the shadow state.
    task automatic predict_pins(input shc_in_t item, output shc_out_t res);
        logic [3:0]  op;
        logic [1:0]  dir_mask;
        logic        level;
        logic        swval;
        shc_status_t st;
        op    = item.opcode;
        st    = ST_OK;
        swval = 1'b0;
        if (op == OP_TICK)
            advance_tick(item.limit_switch1, item.limit_switch2);
        else if (op > OP_READ_SW2)
            st = ST_UNKNOWN;
        else if (phase_r != PH_IDLE)
            st = ST_REJECTED;
        else if (op <= OP_STEP2_AWAY)
        begin
            dir_mask = (op >= OP_STEP2_TOWARD) ? 2'b10 : 2'b01;
            level    = (op >= OP_STEP2_TOWARD) ? home_dir2_r : home_dir1_r;
            if (op == OP_STEP1_AWAY || op == OP_STEP2_AWAY)
                level = ~level;
            dir_r   = level ? (dir_r | dir_mask) : (dir_r & ~dir_mask);
            axis_r  = (op >= OP_STEP2_TOWARD);
            steps_r = item.argument;
            phase_r = PH_SETTLE;
            count_r = reload_value();
        end
        else if (op == OP_HOME)
        begin
            // Only bits 0 and 1 may be set in the homing mask.
            if (item.argument[STEPS_W-1:2] != '0)
                st = ST_BAD_MASK;
            else
            begin
                dir_r    = {home_dir2_r, home_dir1_r};
                homing_r = 2'b00;
                phase_r  = PH_HSETTLE;
                count_r  = reload_value();
            end
        end
        else if (op == OP_READ_SW1)
            swval = item.limit_switch1;
        else
            swval = item.limit_switch2;

        res.step_level1  = step_r[0];
        res.dir_level1   = dir_r[0];
        res.step_level2  = step_r[1];
        res.dir_level2   = dir_r[1];
        res.busy_res     = (phase_r != PH_IDLE);
        res.status       = st;
        res.switch_value = swval;
    endtask

    // Register writes, output comparison and input prediction, edge by edge.
    always @(posedge clk or negedge rst_n)
    begin
        shc_out_t want;
        shc_out_t fresh;
        if (!rst_n)
        begin
            expected_pins_q.delete();
            home_dir1_r      = 1'b0;
            home_dir2_r      = 1'b0;
            delay_r          = DELAY_W'(1);
            phase_r          = PH_IDLE;
            count_r          = '0;
            steps_r          = '0;
            axis_r           = 1'b0;
            homing_r         = 2'b00;
            step_r           = 2'b00;
            dir_r            = 2'b00;
            mismatches       = 0;
            checked          = 0;
            leftover_flagged = 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HOME_DIR1:  home_dir1_r = cfg_data[0];
                    CFG_HOME_DIR2:  home_dir2_r = cfg_data[0];
                    CFG_STEP_DELAY: delay_r     = cfg_data[DELAY_W-1:0];
                    default:        ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                if (expected_pins_q.size() == 0)
                    report_mismatch("result transfer with nothing expected");
                else
                begin
                    want = expected_pins_q.pop_front();
                    check_field("step_level1", 2'(out_data.step_level1),
                                2'(want.step_level1));
                    check_field("dir_level1", 2'(out_data.dir_level1),
                                2'(want.dir_level1));
                    check_field("step_level2", 2'(out_data.step_level2),
                                2'(want.step_level2));
                    check_field("dir_level2", 2'(out_data.dir_level2),
                                2'(want.dir_level2));
                    check_field("busy_res", 2'(out_data.busy_res), 2'(want.busy_res));
                    check_field("status", out_data.status, want.status);
                    check_field("switch_value", 2'(out_data.switch_value),
                                2'(want.switch_value));
                end
                checked++;
            end

            if (in_valid && in_ready)
            begin
                predict_pins(in_data, fresh);
                expected_pins_q.push_back(fresh);
            end

            if (run_done && !leftover_flagged && expected_pins_q.size() != 0)
            begin
                report_mismatch($sformatf("%0d expected results never arrived",
                                          expected_pins_q.size()));
                leftover_flagged = 1'b1;
            end
        end
        fail_count   <= mismatches;
        pending      <= expected_pins_q.size();
        seq_busy     <= (phase_r != PH_IDLE);
        results_seen <= checked;
    end

endmodule

>>> dv/tb_two_axis_stepper_homing_controller.sv
// Testbench top for the stepper homing controller: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_two_axis_stepper_homing_controller;
    import shc_pkg::*;

    localparam int                  RANDOM_PER_SETTING = 210;
    localparam int                  LONG_DELAY_TICKS   = 80;
    localparam logic [DELAY_W-1:0]  LONG_DELAY_VALUE   = 16'd150;
    localparam int                  LONG_HOLD          = 80;
    localparam int                  HOLD_PERIOD        = 900;
    localparam int                  WATCHDOG_LIMIT     = 2000;
    localparam int                  END_SETTLE         = 8;
    localparam logic [3:0]          OP_FIRST_UNKNOWN   = 4'd8;
    localparam logic [3:0]          OP_LAST_UNKNOWN    = 4'd15;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX    = 2'd3;
    localparam logic [STEPS_W-1:0]  ALL_ONES           = '1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid;
    logic                  in_ready;
    shc_in_t               in_data;
    logic                  out_valid;
    logic                  out_ready;
    shc_out_t              out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic run_done;
    int   fail_count;
    int   pending;
    logic seq_busy;
    int   results_seen;

    int items_sent = 0;
    int settings_used = 0;
    int burst_left = 0;
    int quiet_cycles = 0;

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    two_axis_stepper_homing_controller uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    shc_motion_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .run_done     (run_done),
        .fail_count   (fail_count),
        .pending      (pending),
        .seq_busy     (seq_busy),
        .results_seen (results_seen)
    );

    // Offers one item at a falling edge and returns at the falling edge after its transfer.
    task automatic offer_item(input logic [3:0] op, input logic [STEPS_W-1:0] arg,
                              input logic sw1, input logic sw2);
        in_valid              = 1'b1;
        in_data.opcode        = op;
        in_data.argument      = arg;
        in_data.limit_switch1 = sw1;
        in_data.limit_switch2 = sw2;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Bursts of back-to-back transfers separated by random gaps.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic wait_results_drained();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
    endtask

    task automatic apply_setting(input logic hd1, input logic hd2,
                                 input logic [DELAY_W-1:0] delay);
        wait_results_drained();
        write_register(CFG_HOME_DIR1, {15'($urandom()), hd1});
        write_register(CFG_HOME_DIR2, {15'($urandom()), hd2});
        write_register(CFG_STEP_DELAY, delay);
        cfg_we = 1'b0;
        settings_used++;
    endtask

    function automatic logic homing_switch();
        return ($urandom_range(0, 99) < 40);
    endfunction

    task automatic tick_until_idle(input logic sw1, input logic sw2);
        while (seq_busy)
            offer_item(OP_TICK, $urandom(), sw1, sw2);
    endtask

    // Any opcode with random content; idle step counts stay small so that sequences end.
    task automatic send_noise_item();
        logic [3:0]         op;
        logic [STEPS_W-1:0] arg;
        op  = 4'($urandom_range(0, 15));
        arg = $urandom();
        if (!seq_busy && op >= OP_STEP1_TOWARD && op <= OP_STEP2_AWAY)
            arg = $urandom_range(0, 6);
        if (!seq_busy && op == OP_HOME && $urandom_range(0, 1) == 1)
            arg = $urandom_range(0, 3);
        offer_item(op, arg, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // A step or homing command followed by the ticks that carry it to the end.
    task automatic run_motion_sequence();
        logic [3:0]         op;
        logic [STEPS_W-1:0] arg;
        while (seq_busy)
        begin
            pace_sender();
            offer_item(OP_TICK, $urandom(), homing_switch(), homing_switch());
        end
        if ($urandom_range(0, 9) < 6)
        begin
            op  = 4'(OP_STEP1_TOWARD + $urandom_range(0, 3));
            arg = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 5);
        end
        else
        begin
            op  = OP_HOME;
            arg = $urandom_range(0, 3);
        end
        pace_sender();
        offer_item(op, arg, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        while (seq_busy)
        begin
            pace_sender();
            if ($urandom_range(0, 9) == 0)
                send_noise_item();
            else
                offer_item(OP_TICK, $urandom(), homing_switch(), homing_switch());
        end
    endtask

    task automatic random_phase();
        int stop_at;
        stop_at = items_sent + RANDOM_PER_SETTING;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 9) < 7)
                run_motion_sequence();
            else
            begin
                pace_sender();
                send_noise_item();
            end
        end
    endtask

    // Short directed pass with the reset configuration.
    task automatic directed_checks();
        offer_item(OP_TICK, '0, 1'b1, 1'b1);
        offer_item(OP_READ_SW1, ALL_ONES, 1'b1, 1'b0);
        offer_item(OP_READ_SW2, '0, 1'b0, 1'b1);
        offer_item(OP_LAST_UNKNOWN, ALL_ONES, 1'b1, 1'b1);
        offer_item(OP_HOME, ALL_ONES, 1'b0, 1'b0);
        // Zero step count still sets the direction and waits out the settle time.
        offer_item(OP_STEP2_TOWARD, '0, 1'b0, 1'b0);
        tick_until_idle(1'b0, 1'b0);
        // Commands arriving while a move runs are turned away.
        offer_item(OP_STEP1_AWAY, 32'd2, 1'b0, 1'b0);
        offer_item(OP_READ_SW1, '0, 1'b1, 1'b1);
        offer_item(OP_HOME, '0, 1'b0, 1'b0);
        offer_item(OP_FIRST_UNKNOWN, '0, 1'b0, 1'b0);
        tick_until_idle(1'b1, 1'b0);
        // Homing both axes, then axis two alone, then done.
        offer_item(OP_HOME, 32'd3, 1'b1, 1'b1);
        offer_item(OP_TICK, '0, 1'b1, 1'b1);
        offer_item(OP_TICK, '0, 1'b1, 1'b1);
        offer_item(OP_TICK, '0, 1'b0, 1'b1);
        offer_item(OP_TICK, '0, 1'b0, 1'b1);
        offer_item(OP_TICK, '0, 1'b0, 1'b0);
        // Empty mask with both switches already home ends after the settle wait.
        offer_item(OP_HOME, '0, 1'b0, 1'b0);
        offer_item(OP_TICK, '0, 1'b0, 1'b0);
    endtask

    // A long delay, with registers rewritten while the settle wait is still counting.
    task automatic long_delay_phase();
        apply_setting(1'b0, 1'b1, LONG_DELAY_VALUE);
        offer_item(OP_STEP1_AWAY, 32'd1, 1'b0, 1'b0);
        offer_item(OP_READ_SW2, ALL_ONES, 1'b1, 1'b1);
        offer_item(OP_STEP2_TOWARD, 32'd1, 1'b0, 1'b0);
        repeat (LONG_DELAY_TICKS)
            offer_item(OP_TICK, $urandom(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        wait_results_drained();
        write_register(CFG_STEP_DELAY, CFG_DATA_W'(2));
        write_register(CFG_HOME_DIR1, CFG_DATA_W'(1));
        cfg_we = 1'b0;
        settings_used++;
        while (seq_busy)
        begin
            pace_sender();
            offer_item(OP_TICK, $urandom(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    // Main stimulus and verdict.
    initial
    begin
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        run_done  = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_checks();
        random_phase();

        apply_setting(1'b1, 1'b0, '0);
        write_register(CFG_UNUSED_IDX, CFG_DATA_W'($urandom()));
        cfg_we = 1'b0;
        random_phase();
        apply_setting(1'b0, 1'b1, DELAY_W'(2));
        random_phase();
        apply_setting(1'b1, 1'b1, DELAY_W'(4));
        random_phase();
        apply_setting(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      DELAY_W'($urandom_range(1, 3)));
        random_phase();

        long_delay_phase();

        wait_results_drained();
        repeat (END_SETTLE) @(negedge clk);
        run_done = 1'b1;
        repeat (2) @(negedge clk);

        $display("Sent %0d input transfers and checked %0d result transfers over %0d settings.",
                 items_sent, results_seen, settings_used);
        $display("Covered stepping, homing, switch reads, bad masks, busy and unknown commands.");
        if (fail_count == 0)
            $display("tb_two_axis_stepper_homing_controller OK");
        else
            $display("tb_two_axis_stepper_homing_controller NOT OK");
        $finish;
    end

    // Receiver: stretches of different stall patterns, with a long hold-off now and then.
    initial
    begin
        int mode;
        int span;
        int rx_cycles;
        out_ready = 1'b0;
        rx_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 64);
            repeat (span)
            begin
                @(negedge clk);
                rx_cycles++;
                if (rx_cycles % HOLD_PERIOD == HOLD_PERIOD / 2)
                begin
                    out_ready = 1'b0;
                    repeat (LONG_HOLD - 1) @(negedge clk);
                    rx_cycles += LONG_HOLD - 1;
                end
                else
                begin
                    case (mode)
                        0:       out_ready = 1'b1;
                        1:       out_ready = 1'($urandom_range(0, 1));
                        2:       out_ready = ($urandom_range(0, 4) != 0);
                        default: out_ready = ((rx_cycles % 4) != 0);
                    endcase
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb_two_axis_stepper_homing_controller NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
